@@ rtl/core/knife_edge_diffraction_loss_assert.svh @@
// ----------------------------------------------------------------------------
// Knife-edge diffraction loss assertion macros
// Shared property forms for the checker of the diffraction loss block.
// ----------------------------------------------------------------------------
`ifndef KNIFE_EDGE_DIFFRACTION_LOSS_ASSERT_SVH
`define KNIFE_EDGE_DIFFRACTION_LOSS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KEDL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define KEDL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define KEDL_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

@@ rtl/core/kedl_pkg.sv @@
// ----------------------------------------------------------------------------
// Knife-edge diffraction loss package
// Shared widths, region codes, fixed-point constants and the queue item type.
// ----------------------------------------------------------------------------
`default_nettype none

package kedl_pkg;

  localparam int FRAC_BITS = 10;
  localparam int IN_W      = 16;
  localparam int LOSS_W    = 16;
  localparam int RGN_W     = 3;
  localparam int OPND_W    = 34;
  localparam int NEGLOG_W  = 38;

  localparam logic [RGN_W-1:0] RGN_NONE = 3'd0;
  localparam logic [RGN_W-1:0] RGN_NEG  = 3'd1;
  localparam logic [RGN_W-1:0] RGN_LOW  = 3'd2;
  localparam logic [RGN_W-1:0] RGN_MID  = 3'd3;
  localparam logic [RGN_W-1:0] RGN_HIGH = 3'd4;

  localparam logic [31:0] Q32_HALF     = 32'h8000_0000;
  localparam logic [31:0] Q32_0P4      = 32'd1717986918;
  localparam logic [31:0] Q32_0P38     = 32'd1632087572;
  localparam logic [31:0] Q32_0P1184   = 32'd508524128;
  localparam logic [33:0] Q32_SLOPE    = 34'd5886511618;
  localparam logic [33:0] Q32_NLOG0225 = 34'd9242782908;
  localparam logic [22:0] DB_OCT_Q20   = 23'd6313057;

  localparam int ROOT_STEPS = 31;
  localparam int NORM_STEPS = 5;
  localparam int LOG_STEPS  = 32;
  localparam int ROOT_LAT   = ROOT_STEPS + 3;
  localparam int LOG_LAT    = NORM_STEPS + LOG_STEPS;
  localparam int BACK_LAT   = ROOT_LAT + LOG_LAT + 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [RGN_W-1:0]  region;
    logic [OPND_W-1:0] opnd;
  } kedl_item_t;

endpackage

`default_nettype wire

@@ rtl/core/kedl_front.sv @@
// ----------------------------------------------------------------------------
// Diffraction loss front end
// Classifies v into its region and forms the operand that the back end needs.
// ----------------------------------------------------------------------------
`default_nettype none

module kedl_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [kedl_pkg::IN_W-1:0]   diff_param,
  output logic                               item_valid,
  input  logic                               item_ready,
  output kedl_pkg::kedl_item_t               item
);
  import kedl_pkg::*;

  localparam int ONE    = 1 << FRAC_BITS;
  localparam int S1     = 30 - FRAC_BITS;
  localparam int C1     = (1 << S1) / 25;
  localparam int C2     = (1 << S1) % 25;
  localparam int K25_SH = 27;
  localparam int K25    = ((1 << K25_SH) + 24) / 25;
  localparam int K25B   = ((1 << 16) + 24) / 25;
  localparam int S2     = 31 - FRAC_BITS;
  localparam int D1     = (1 << S2) / 5;
  localparam int D2     = (1 << S2) % 5;
  localparam int K5     = ((1 << 20) + 4) / 5;

  localparam logic signed [23:0] LIM_NONE = 24'(-4 * ONE);
  localparam logic signed [23:0] LIM_ONE  = 24'(ONE);
  localparam logic signed [23:0] LIM_MID  = 24'(12 * ONE);

  logic signed [23:0] vx;
  logic signed [23:0] v5;
  logic [15:0]        mag;
  logic [15:0]        vu;
  logic [21:0]        a62;
  logic [44:0]        pa;
  logic [47:0]        hi3;
  logic [18:0]        w3;
  logic [49:0]        p2;
  logic [2:0]         region_c;

  logic               s1_valid;
  logic [2:0]         s1_region;
  logic [15:0]        s1_vu;
  logic [21:0]        s1_a62;
  logic [44:0]        s1_pa;
  logic [47:0]        s1_hi3;
  logic [18:0]        s1_w3;
  logic [49:0]        s1_p2;

  logic [17:0]        a25;
  logic [4:0]         b25;
  logic [9:0]         wb;
  logic [4:0]         qb;
  logic [33:0]        t1;
  logic [31:0]        arg1;
  logic [17:0]        lo3;
  logic [47:0]        tenth;
  logic [31:0]        s3;
  logic [33:0]        neg2;
  kedl_item_t         item_c;

  logic               s2_valid;
  kedl_item_t         s2_item;
  logic               en1;
  logic               en2;

  assign vx  = 24'(diff_param);
  assign v5  = (vx <<< 2) + vx;
  assign mag = 16'(-vx);
  assign vu  = diff_param;
  assign a62 = (22'(mag) << 6) - (22'(mag) << 1);
  assign pa  = 45'(a62) * 45'(K25);
  assign hi3 = 48'(vu) * 48'(D1);
  assign w3  = 19'(vu) * 19'(D2) + 19'd2;
  assign p2  = 50'(vu) * 50'(Q32_SLOPE);

  always_comb begin
    if (v5 <= LIM_NONE) begin
      region_c = RGN_NONE;
    end else if (vx < 24'sd0) begin
      region_c = RGN_NEG;
    end else if (vx < LIM_ONE) begin
      region_c = RGN_LOW;
    end else if (v5 < LIM_MID) begin
      region_c = RGN_MID;
    end else begin
      region_c = RGN_HIGH;
    end
  end

  assign en2      = !s2_valid || item_ready;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= in_valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_region <= region_c;
      s1_vu     <= vu;
      s1_a62    <= a62;
      s1_pa     <= pa;
      s1_hi3    <= hi3;
      s1_w3     <= w3;
      s1_p2     <= p2;
    end
  end

  assign a25   = 18'(s1_pa >> K25_SH);
  assign b25   = 5'(s1_a62 - 22'(a25) * 22'd25);
  assign wb    = 10'(b25) * 10'(C2) + 10'd12;
  assign qb    = 5'((26'(wb) * 26'(K25B)) >> 16);
  assign t1    = (34'(a25) << S1) + 34'(b25) * 34'(C1) + 34'(qb);
  assign arg1  = Q32_HALF + t1[31:0];
  assign lo3   = 18'((38'(s1_w3) * 38'(K5)) >> 20);
  assign tenth = s1_hi3 + 48'(lo3);
  assign s3    = Q32_0P38 - tenth[31:0];
  assign neg2  = {2'b01, 32'd0} + 34'(s1_p2 >> FRAC_BITS);

  always_comb begin
    item_c.region = s1_region;
    case (s1_region)
      RGN_NEG:  item_c.opnd = 34'(arg1);
      RGN_LOW:  item_c.opnd = neg2;
      RGN_MID:  item_c.opnd = 34'(s3);
      RGN_HIGH: item_c.opnd = 34'(s1_vu);
      default:  item_c.opnd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      s2_item <= item_c;
    end
  end

  assign item_valid = s2_valid;
  assign item       = s2_item;

endmodule

`default_nettype wire

@@ rtl/core/kedl_fifo.sv @@
// ----------------------------------------------------------------------------
// Diffraction loss request queue
// Short show-ahead queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kedl_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  kedl_pkg::kedl_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kedl_pkg::kedl_item_t  out_item
);
  import kedl_pkg::*;

  kedl_item_t           slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     count;
  logic [FIFO_AW:0]     count_next;
  logic                 push;
  logic                 pop;

  assign in_ready  = count != (FIFO_AW + 1)'(FIFO_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/kedl_root.sv @@
// ----------------------------------------------------------------------------
// Diffraction loss square root pipeline
// Forms 0.4 - sqrt(0.1184 - s^2) for the [1, 2.4) region, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kedl_root (
  input  logic                  clk,
  input  logic                  en,
  input  kedl_pkg::kedl_item_t  in_item,
  output kedl_pkg::kedl_item_t  out_item
);
  import kedl_pkg::*;

  kedl_item_t   tg0;
  logic [29:0]  sq0;
  logic [61:0]  sq_full;
  logic [28:0]  diff1;

  logic [61:0]  rn [ROOT_STEPS+1];
  logic [61:0]  rr [ROOT_STEPS+1];
  kedl_item_t   rt [ROOT_STEPS+1];

  logic [31:0]  root_val;
  logic [31:0]  arg;

  assign sq_full = 62'(in_item.opnd[30:0]) * 62'(in_item.opnd[30:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      tg0 <= in_item;
      sq0 <= sq_full[61:32];
    end
  end

  assign diff1 = (30'(Q32_0P1184) < sq0) ? 29'd0 : 29'(30'(Q32_0P1184) - sq0);

  always_ff @(posedge clk) begin
    if (en) begin
      rt[0] <= tg0;
      rn[0] <= {1'b0, diff1, 32'd0};
      rr[0] <= '0;
    end
  end

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);
    logic [61:0] trial;
    assign trial = rr[j] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        rt[j+1] <= rt[j];
        if (rn[j] >= trial) begin
          rn[j+1] <= rn[j] - trial;
          rr[j+1] <= (rr[j] >> 1) + BIT;
        end else begin
          rn[j+1] <= rn[j];
          rr[j+1] <= rr[j] >> 1;
        end
      end
    end
  end

  assign root_val = rr[ROOT_STEPS][31:0];
  assign arg      = (root_val >= Q32_0P4) ? 32'd1 : Q32_0P4 - root_val;

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.region <= rt[ROOT_STEPS].region;
      if (rt[ROOT_STEPS].region == RGN_MID) begin
        out_item.opnd <= 34'(arg);
      end else begin
        out_item.opnd <= rt[ROOT_STEPS].opnd;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/kedl_log.sv @@
// ----------------------------------------------------------------------------
// Diffraction loss log2 pipeline
// Normalizes the operand over five stages, then extracts 32 fraction bits
// of log2 by repeated squaring, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kedl_log (
  input  logic                  clk,
  input  logic                  en,
  input  kedl_pkg::kedl_item_t  in_item,
  output kedl_pkg::kedl_item_t  out_item,
  output logic [4:0]            lz,
  output logic [31:0]           frac
);
  import kedl_pkg::*;

  logic [31:0]  x_in;
  logic [31:0]  x0;

  logic [31:0]  nx  [NORM_STEPS];
  logic [4:0]   nz  [NORM_STEPS];
  kedl_item_t   ntg [NORM_STEPS];

  logic [30:0]  sm  [LOG_STEPS];
  logic [31:0]  sf  [LOG_STEPS];
  logic [4:0]   sz  [LOG_STEPS];
  kedl_item_t   stg [LOG_STEPS];

  assign x_in = in_item.opnd[31:0];
  assign x0   = (x_in == '0) ? 32'd1 : x_in;

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int SH = 16 >> k;
    logic [31:0] xi;
    logic [4:0]  zi;
    kedl_item_t  ti;
    if (k == 0) begin : g_first
      assign xi = x0;
      assign zi = '0;
      assign ti = in_item;
    end else begin : g_next
      assign xi = nx[k-1];
      assign zi = nz[k-1];
      assign ti = ntg[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ntg[k] <= ti;
        if (xi[31 -: SH] == '0) begin
          nx[k] <= xi << SH;
          nz[k] <= zi + 5'(SH);
        end else begin
          nx[k] <= xi;
          nz[k] <= zi;
        end
      end
    end
  end

  for (genvar i = 0; i < LOG_STEPS; i++) begin : g_sqr
    localparam logic [31:0] BIT = 32'h8000_0000 >> i;
    logic [30:0] mi;
    logic [31:0] fi;
    logic [4:0]  zi;
    kedl_item_t  ti;
    logic [61:0] mm;
    logic [31:0] tq;
    if (i == 0) begin : g_first
      assign mi = nx[NORM_STEPS-1][31:1];
      assign fi = '0;
      assign zi = nz[NORM_STEPS-1];
      assign ti = ntg[NORM_STEPS-1];
    end else begin : g_next
      assign mi = sm[i-1];
      assign fi = sf[i-1];
      assign zi = sz[i-1];
      assign ti = stg[i-1];
    end
    assign mm = 62'(mi) * 62'(mi);
    assign tq = mm[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        sz[i]  <= zi;
        stg[i] <= ti;
        if (tq[31]) begin
          sm[i] <= tq[31:1];
          sf[i] <= fi | BIT;
        end else begin
          sm[i] <= tq[30:0];
          sf[i] <= fi;
        end
      end
    end
  end

  assign out_item = stg[LOG_STEPS-1];
  assign lz       = sz[LOG_STEPS-1];
  assign frac     = sf[LOG_STEPS-1];

endmodule

`default_nettype wire

@@ rtl/core/kedl_back.sv @@
// ----------------------------------------------------------------------------
// Diffraction loss back end
// Runs the root and log pipelines, scales the negated log2 to dB, rounds and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module kedl_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  kedl_pkg::kedl_item_t          in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kedl_pkg::LOSS_W-1:0]   loss_db,
  output logic [kedl_pkg::RGN_W-1:0]    region
);
  import kedl_pkg::*;

  localparam int RQ_W = 10 + FRAC_BITS;
  localparam logic [61:0] RND = 62'd1 << (51 - FRAC_BITS);

  logic                   en;
  logic [BACK_LAT-1:0]    vld;
  kedl_item_t             root_item;
  kedl_item_t             log_item;
  logic [4:0]             lz;
  logic [31:0]            frac;

  logic [5:0]             p;
  logic [NEGLOG_W-1:0]    neglog_c;
  logic [NEGLOG_W-1:0]    n1_neglog;
  logic [RGN_W-1:0]       n1_region;
  logic [54:0]            n2_lo;
  logic [28:0]            n2_hi;
  logic [RGN_W-1:0]       n2_region;
  logic [61:0]            prod;
  logic [RQ_W-1:0]        rq;
  logic [LOSS_W-1:0]      loss_c;

  assign en       = !vld[BACK_LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[BACK_LAT-2:0], in_valid};
    end
  end

  kedl_root u_root (
    .clk      (clk),
    .en       (en),
    .in_item  (in_item),
    .out_item (root_item)
  );

  kedl_log u_log (
    .clk      (clk),
    .en       (en),
    .in_item  (root_item),
    .out_item (log_item),
    .lz       (lz),
    .frac     (frac)
  );

  assign p = 6'd31 - {1'b0, lz};

  always_comb begin
    case (log_item.region)
      RGN_LOW:  neglog_c = 38'(log_item.opnd);
      RGN_NEG:  neglog_c = {6'd32 - p, 32'd0} - 38'(frac);
      RGN_MID:  neglog_c = {6'd32 - p, 32'd0} - 38'(frac);
      RGN_HIGH: neglog_c = {p - 6'(FRAC_BITS), 32'd0} + 38'(frac) + 38'(Q32_NLOG0225);
      default:  neglog_c = '0;
    endcase
  end

  assign prod   = 62'({n2_hi, 32'd0}) + 62'(n2_lo) + RND;
  assign rq     = prod[61 -: RQ_W];
  assign loss_c = (rq > RQ_W'(16'hFFFF)) ? 16'hFFFF : rq[15:0];

  always_ff @(posedge clk) begin
    if (en) begin
      n1_neglog <= neglog_c;
      n1_region <= log_item.region;
      n2_lo     <= 55'(n1_neglog[31:0]) * 55'(DB_OCT_Q20);
      n2_hi     <= 29'(n1_neglog[37:32]) * 29'(DB_OCT_Q20);
      n2_region <= n1_region;
      loss_db   <= loss_c;
      region    <= n2_region;
    end
  end

  assign out_valid = vld[BACK_LAT-1];

endmodule

`default_nettype wire

@@ rtl/core/knife_edge_diffraction_loss.sv @@
// Throughput: one request per cycle while the output is not stalled, set by the 34-stage
// root and 37-stage log2 pipelines, which each take a new request every cycle they are enabled.
// A 4-entry queue lets the front end keep accepting while the output stalls, until it fills.
// Reset: rst clears the valid flags and the queue; data registers are not reset.
// ----------------------------------------------------------------------------
// Knife-edge diffraction loss
// Single knife-edge loss in dB from the diffraction parameter v, using the
// four-region piecewise approximation.
// ----------------------------------------------------------------------------
`default_nettype none

module knife_edge_diffraction_loss (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [kedl_pkg::IN_W-1:0]   diff_param,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [kedl_pkg::LOSS_W-1:0]        loss_db,
  output logic [kedl_pkg::RGN_W-1:0]         region
);
  import kedl_pkg::*;

  logic        fr_valid;
  logic        fr_ready;
  kedl_item_t  fr_item;
  logic        q_valid;
  logic        q_ready;
  kedl_item_t  q_item;

  kedl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .diff_param (diff_param),
    .item_valid (fr_valid),
    .item_ready (fr_ready),
    .item       (fr_item)
  );

  kedl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_item   (fr_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  kedl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .loss_db   (loss_db),
    .region    (region)
  );

endmodule

`default_nettype wire

@@ rtl/core/kedl_checker.sv @@
// ----------------------------------------------------------------------------
// Knife-edge diffraction loss checker
// Port-level properties of the diffraction loss block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "knife_edge_diffraction_loss_assert.svh"

module kedl_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [kedl_pkg::IN_W-1:0]   diff_param,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [kedl_pkg::LOSS_W-1:0]        loss_db,
  input  logic [kedl_pkg::RGN_W-1:0]         region
);
  import kedl_pkg::*;

  // The [0, 1) region never falls below 20 log10(2) dB.
  localparam logic [LOSS_W-1:0] LOW_FLOOR = 16'd6165;

  `KEDL_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(diff_param), "request dropped or changed while waiting")
  `KEDL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(loss_db) && $stable(region), "result changed while stalled")
  `KEDL_ASSERT_IMP(a_none_zero, out_valid && (region == RGN_NONE), loss_db == '0, "nonzero loss outside the shadow")
  `KEDL_ASSERT_IMP(a_low_floor, out_valid && (region == RGN_LOW), loss_db >= LOW_FLOOR, "loss below 6 dB in the [0, 1) region")
  `KEDL_ASSERT_RST(a_rst_empty, !out_valid, "result offered right after reset")

endmodule

bind knife_edge_diffraction_loss kedl_checker u_kedl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .diff_param (diff_param),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .loss_db    (loss_db),
  .region     (region)
);

`default_nettype wire
